// ===== hdl/bvrs_pkg.sv =====
// ----------------------------------------------------------------------------
// Bit vector rank/select package
// Types, sizes, codes and the population count shared by the block's modules.
// ----------------------------------------------------------------------------
package bvrs_pkg;

   // Storage geometry: 64K bits in 32-bit words, superblocks of 256 bits.
   localparam int MAX_BITS  = 65536;
   localparam int NWORDS    = 2048;
   localparam int NSUPERS   = 257;
   localparam int NBLOCKS   = 2049;
   localparam int WORD_AW   = 11;
   localparam int SUPER_AW  = 9;
   localparam int BLOCK_AW  = 12;

   // Operation codes of a request word.
   localparam logic [2:0] OP_APPEND = 3'd0;
   localparam logic [2:0] OP_BUILD  = 3'd1;
   localparam logic [2:0] OP_RANK   = 3'd2;
   localparam logic [2:0] OP_SELECT = 3'd3;
   localparam logic [2:0] OP_READ   = 3'd4;

   typedef enum logic [4:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_APP_RD,
      ST_APP_WR,
      ST_BLD_RD,
      ST_BLD_ACC,
      ST_RANK_RD,
      ST_RANK_POP,
      ST_RANK_SUM,
      ST_READ_RD,
      ST_READ_BIT,
      ST_SEL_BS,
      ST_SEL_BSCMP,
      ST_SEL_PS,
      ST_SEL_PSSUB,
      ST_SEL_SCAN,
      ST_SEL_SCMP,
      ST_SEL_BACK,
      ST_SEL_BSUB,
      ST_SEL_H16,
      ST_SEL_H8,
      ST_SEL_BITS,
      ST_OUT
   } state_type;

   // Access of the bit word memory.
   typedef struct packed {
      logic               we;
      logic [WORD_AW-1:0] waddr;
      logic [31:0]        wdata;
      logic [WORD_AW-1:0] raddr;
   } word_mem_req_type;

   // Access of the superblock count memory.
   typedef struct packed {
      logic                we;
      logic [SUPER_AW-1:0] waddr;
      logic [16:0]         wdata;
      logic [SUPER_AW-1:0] raddr;
   } super_mem_req_type;

   // Access of the per-word block count memory.
   typedef struct packed {
      logic                we;
      logic [BLOCK_AW-1:0] waddr;
      logic [7:0]          wdata;
      logic [BLOCK_AW-1:0] raddr;
   } block_mem_req_type;

   // Number of ones in a 32-bit word, by pairwise folding.
   function automatic logic [5:0] ones32(input logic [31:0] v);
      logic [31:0] t;
      t = ((v & 32'hAAAAAAAA) >> 1) + (v & 32'h55555555);
      t = ((t & 32'hCCCCCCCC) >> 2) + (t & 32'h33333333);
      t = ((t >> 4) + t) & 32'h0F0F0F0F;
      t = (t >> 8) + t;
      t = (t >> 16) + t;
      return t[5:0];
   endfunction

endpackage

// ===== hdl/bvrs_if.sv =====
// ----------------------------------------------------------------------------
// Bit vector rank/select channels
// Valid/ready channels for request words and response words.
// ----------------------------------------------------------------------------
interface bvrs_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic        bit_value;
   logic [15:0] position;
   logic [16:0] occurrence;

   modport source(output valid, operation, bit_value, position, occurrence, input ready);
   modport sink(input valid, operation, bit_value, position, occurrence, output ready);
endinterface

interface bvrs_rsp_if;
   logic        valid;
   logic        ready;
   logic [16:0] count;
   logic [15:0] found_position;
   logic        bit_read;
   logic        error;

   modport source(output valid, count, found_position, bit_read, error, input ready);
   modport sink(input valid, count, found_position, bit_read, error, output ready);
endinterface

// ===== hdl/bvrs_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module bvrs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hdl/bvrs_ctrl.sv =====
// ----------------------------------------------------------------------------
// Bit vector rank/select sequencer
// Runs each operation as a series of memory reads and write-backs. Items are
// handled one at a time, so no two accesses to one entry ever overlap.
// ----------------------------------------------------------------------------
module bvrs_ctrl import bvrs_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   bvrs_req_if.sink          req_if,
   bvrs_rsp_if.source        rsp_if,
   output word_mem_req_type  word_req,
   input  logic [31:0]       word_rdata,
   output super_mem_req_type super_req,
   input  logic [16:0]       super_rdata,
   output block_mem_req_type block_req,
   input  logic [7:0]        block_rdata
);

   state_type   state_ff, state_in;
   logic [16:0] len_ff, len_in;
   logic [16:0] blen_ff, blen_in;
   logic [16:0] bones_ff, bones_in;
   logic        b_ff, b_in;
   logic [15:0] pos_ff, pos_in;
   logic [16:0] x_ff, x_in;
   logic [11:0] wcnt_ff, wcnt_in;
   logic [16:0] sum_ff, sum_in;
   logic [16:0] base_ff, base_in;
   logic [8:0]  left_ff, left_in;
   logic [8:0]  right_ff, right_in;
   logic [8:0]  mid_ff, mid_in;
   logic [15:0] ret_ff, ret_in;
   logic [31:0] cur_ff, cur_in;
   logic [5:0]  bitcnt_ff, bitcnt_in;
   logic [16:0] part_ff, part_in;
   logic [5:0]  pop_ff, pop_in;
   logic [16:0] res_count_ff, res_count_in;
   logic [15:0] res_pos_ff, res_pos_in;
   logic        res_bit_ff, res_bit_in;
   logic        res_err_ff, res_err_in;
   logic        rsp_valid_ff, rsp_valid_in;
   logic [16:0] rsp_count_ff, rsp_count_in;
   logic [15:0] rsp_pos_ff, rsp_pos_in;
   logic        rsp_bit_ff, rsp_bit_in;
   logic        rsp_err_ff, rsp_err_in;

   // Helper values for the combinational block.
   logic [16:0] total;
   logic [16:0] pos1;
   logic [31:0] mask;
   logic [9:0]  mid_sum;
   logic [16:0] match;
   logic [11:0] nblk;
   logic [11:0] pw_dec;
   logic [8:0]  ps;
   logic [5:0]  pop;
   logic [16:0] r1;

   // Control and payload registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         len_ff       <= '0;
         blen_ff      <= '0;
         bones_ff     <= '0;
         wcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         len_ff       <= len_in;
         blen_ff      <= blen_in;
         bones_ff     <= bones_in;
         wcnt_ff      <= wcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      b_ff         <= b_in;
      pos_ff       <= pos_in;
      x_ff         <= x_in;
      sum_ff       <= sum_in;
      base_ff      <= base_in;
      left_ff      <= left_in;
      right_ff     <= right_in;
      mid_ff       <= mid_in;
      ret_ff       <= ret_in;
      cur_ff       <= cur_in;
      bitcnt_ff    <= bitcnt_in;
      part_ff      <= part_in;
      pop_ff       <= pop_in;
      res_count_ff <= res_count_in;
      res_pos_ff   <= res_pos_in;
      res_bit_ff   <= res_bit_in;
      res_err_ff   <= res_err_in;
      rsp_count_ff <= rsp_count_in;
      rsp_pos_ff   <= rsp_pos_in;
      rsp_bit_ff   <= rsp_bit_in;
      rsp_err_ff   <= rsp_err_in;
   end

   // Next state, memory accesses and datapath.
   always_comb begin
      state_in     = state_ff;
      len_in       = len_ff;
      blen_in      = blen_ff;
      bones_in     = bones_ff;
      b_in         = b_ff;
      pos_in       = pos_ff;
      x_in         = x_ff;
      wcnt_in      = wcnt_ff;
      sum_in       = sum_ff;
      base_in      = base_ff;
      left_in      = left_ff;
      right_in     = right_ff;
      mid_in       = mid_ff;
      ret_in       = ret_ff;
      cur_in       = cur_ff;
      bitcnt_in    = bitcnt_ff;
      part_in      = part_ff;
      pop_in       = pop_ff;
      res_count_in = res_count_ff;
      res_pos_in   = res_pos_ff;
      res_bit_in   = res_bit_ff;
      res_err_in   = res_err_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_count_in = rsp_count_ff;
      rsp_pos_in   = rsp_pos_ff;
      rsp_bit_in   = rsp_bit_ff;
      rsp_err_in   = rsp_err_ff;
      word_req     = '0;
      super_req    = '0;
      block_req    = '0;

      total   = req_if.bit_value ? bones_ff : blen_ff - bones_ff;
      pos1    = {1'b0, pos_ff} + 17'd1;
      mask    = 32'((33'd1 << pos1[4:0]) - 33'd1);
      mid_sum = {1'b0, left_ff} + {1'b0, right_ff};
      nblk    = blen_ff[16:5] + 12'd1;
      pw_dec  = wcnt_ff - 12'd1;
      ps      = (left_ff != 9'd0) ? left_ff - 9'd1 : 9'd0;
      match   = '0;
      pop     = '0;
      r1      = '0;

      // The response register drains independently of the sequencer.
      if (rsp_valid_ff && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         // Zero the bit memory one word per cycle after reset.
         ST_CLEAR: begin
            word_req.we    = 1'b1;
            word_req.waddr = wcnt_ff[WORD_AW-1:0];
            wcnt_in        = wcnt_ff + 12'd1;
            if (wcnt_ff == 12'(NWORDS - 1)) begin
               wcnt_in  = '0;
               state_in = ST_IDLE;
            end
         end

         // Take a request word and start its operation.
         ST_IDLE: begin
            if (req_if.valid) begin
               b_in         = req_if.bit_value;
               pos_in       = req_if.position;
               res_count_in = '0;
               res_pos_in   = '0;
               res_bit_in   = 1'b0;
               res_err_in   = 1'b0;
               case (req_if.operation)
                  OP_APPEND: begin
                     if (len_ff[16]) begin
                        res_err_in = 1'b1;
                        state_in   = ST_OUT;
                     end else if (req_if.bit_value) begin
                        state_in = ST_APP_RD;
                     end else begin
                        len_in = len_ff + 17'd1;
                     end
                  end
                  OP_BUILD: begin
                     wcnt_in  = '0;
                     sum_in   = '0;
                     base_in  = '0;
                     state_in = ST_BLD_RD;
                  end
                  OP_RANK: begin
                     state_in = ST_RANK_RD;
                  end
                  OP_SELECT: begin
                     if (req_if.occurrence == 17'd0 || req_if.occurrence > total) begin
                        res_err_in = 1'b1;
                        state_in   = ST_OUT;
                     end else begin
                        x_in     = req_if.occurrence;
                        left_in  = '0;
                        right_in = blen_ff[16:8] + 9'd1;
                        state_in = ST_SEL_BS;
                     end
                  end
                  OP_READ: begin
                     state_in = ST_READ_RD;
                  end
                  default: begin
                  end
               endcase
            end
         end

         // Append a one: read the last word, set the bit, write it back.
         ST_APP_RD: begin
            word_req.raddr = len_ff[15:5];
            state_in       = ST_APP_WR;
         end
         ST_APP_WR: begin
            word_req.we    = 1'b1;
            word_req.waddr = len_ff[15:5];
            word_req.wdata = word_rdata | (32'd1 << len_ff[4:0]);
            len_in         = len_ff + 17'd1;
            state_in       = ST_IDLE;
         end

         // Build: walk every word up to the length and fill both count tables.
         ST_BLD_RD: begin
            word_req.raddr = wcnt_ff[WORD_AW-1:0];
            state_in       = ST_BLD_ACC;
         end
         ST_BLD_ACC: begin
            pop             = wcnt_ff[11] ? 6'd0 : ones32(word_rdata);
            block_req.we    = 1'b1;
            block_req.waddr = wcnt_ff;
            if (wcnt_ff[2:0] == 3'd0) begin
               super_req.we    = 1'b1;
               super_req.waddr = wcnt_ff[11:3];
               super_req.wdata = sum_ff;
               base_in         = sum_ff;
               block_req.wdata = '0;
            end else begin
               block_req.wdata = 8'(sum_ff - base_ff);
            end
            sum_in = sum_ff + {11'd0, pop};
            if (wcnt_ff == len_ff[16:5]) begin
               blen_in  = len_ff;
               bones_in = sum_ff + {11'd0, pop};
               state_in = ST_IDLE;
            end else begin
               wcnt_in  = wcnt_ff + 12'd1;
               state_in = ST_BLD_RD;
            end
         end

         // Rank: superblock count, block count and masked word in parallel.
         ST_RANK_RD: begin
            super_req.raddr = pos1[16:8];
            block_req.raddr = pos1[16:5];
            word_req.raddr  = pos_ff[15:5];
            state_in        = ST_RANK_POP;
         end
         ST_RANK_POP: begin
            part_in  = super_rdata + {9'd0, block_rdata};
            pop_in   = ones32(word_rdata & mask);
            state_in = ST_RANK_SUM;
         end
         ST_RANK_SUM: begin
            r1           = part_ff + {11'd0, pop_ff};
            res_count_in = b_ff ? r1 : pos1 - r1;
            state_in     = ST_OUT;
         end

         // Read one stored bit.
         ST_READ_RD: begin
            word_req.raddr = pos_ff[15:5];
            state_in       = ST_READ_BIT;
         end
         ST_READ_BIT: begin
            res_bit_in = word_rdata[pos_ff[4:0]];
            state_in   = ST_OUT;
         end

         // Select: binary search over superblock counts.
         ST_SEL_BS: begin
            if (left_ff < right_ff) begin
               mid_in          = mid_sum[9:1];
               super_req.raddr = mid_sum[9:1];
               state_in        = ST_SEL_BSCMP;
            end else begin
               state_in = ST_SEL_PS;
            end
         end
         ST_SEL_BSCMP: begin
            match = b_ff ? super_rdata : {mid_ff, 8'd0} - super_rdata;
            if (match < x_ff) begin
               left_in = mid_ff + 9'd1;
            end else begin
               right_in = mid_ff;
            end
            state_in = ST_SEL_BS;
         end
         ST_SEL_PS: begin
            super_req.raddr = ps;
            mid_in          = ps;
            state_in        = ST_SEL_PSSUB;
         end
         ST_SEL_PSSUB: begin
            match    = b_ff ? super_rdata : {mid_ff, 8'd0} - super_rdata;
            x_in     = x_ff - match;
            wcnt_in  = {mid_ff, 3'd1};
            state_in = ST_SEL_SCAN;
         end

         // Select: scan the block counts inside the superblock.
         ST_SEL_SCAN: begin
            if (wcnt_ff < nblk && wcnt_ff[2:0] != 3'd0) begin
               block_req.raddr = wcnt_ff;
               state_in        = ST_SEL_SCMP;
            end else begin
               state_in = ST_SEL_BACK;
            end
         end
         ST_SEL_SCMP: begin
            match = b_ff ? {9'd0, block_rdata}
                         : {9'd0, wcnt_ff[2:0], 5'd0} - {9'd0, block_rdata};
            if (match < x_ff) begin
               wcnt_in  = wcnt_ff + 12'd1;
               state_in = ST_SEL_SCAN;
            end else begin
               state_in = ST_SEL_BACK;
            end
         end
         ST_SEL_BACK: begin
            wcnt_in         = pw_dec;
            block_req.raddr = pw_dec;
            word_req.raddr  = pw_dec[WORD_AW-1:0];
            state_in        = ST_SEL_BSUB;
         end
         ST_SEL_BSUB: begin
            match = b_ff ? {9'd0, block_rdata}
                         : {9'd0, wcnt_ff[2:0], 5'd0} - {9'd0, block_rdata};
            x_in     = x_ff - match;
            cur_in   = wcnt_ff[11] ? 32'd0 : word_rdata;
            ret_in   = {wcnt_ff[10:0], 5'd0};
            state_in = ST_SEL_H16;
         end

         // Select: narrow to a half word, then a byte.
         ST_SEL_H16: begin
            pop   = ones32({16'd0, cur_ff[15:0]});
            match = b_ff ? {11'd0, pop} : 17'd16 - {11'd0, pop};
            if (match < x_ff) begin
               cur_in = cur_ff >> 16;
               ret_in = ret_ff + 16'd16;
               x_in   = x_ff - match;
            end
            state_in = ST_SEL_H8;
         end
         ST_SEL_H8: begin
            pop   = ones32({24'd0, cur_ff[7:0]});
            match = b_ff ? {11'd0, pop} : 17'd8 - {11'd0, pop};
            if (match < x_ff) begin
               cur_in = cur_ff >> 8;
               ret_in = ret_ff + 16'd8;
               x_in   = x_ff - match;
            end
            bitcnt_in = '0;
            state_in  = ST_SEL_H8 == state_ff ? ST_SEL_BITS : state_ff;
         end

         // Select: one bit per cycle until the wanted occurrence is passed.
         ST_SEL_BITS: begin
            if (bitcnt_ff < 6'd32 && x_ff != 17'd0) begin
               if (cur_ff[0] == b_ff) begin
                  x_in = x_ff - 17'd1;
               end
               cur_in    = cur_ff >> 1;
               ret_in    = ret_ff + 16'd1;
               bitcnt_in = bitcnt_ff + 6'd1;
            end else begin
               res_pos_in = ret_ff - 16'd1;
               state_in   = ST_OUT;
            end
         end

         // Hand the result to the response register once it is free.
         ST_OUT: begin
            if (!rsp_valid_ff || rsp_if.ready) begin
               rsp_valid_in = 1'b1;
               rsp_count_in = res_count_ff;
               rsp_pos_in   = res_pos_ff;
               rsp_bit_in   = res_bit_ff;
               rsp_err_in   = res_err_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign req_if.ready          = (state_ff == ST_IDLE);
   assign rsp_if.valid          = rsp_valid_ff;
   assign rsp_if.count          = rsp_count_ff;
   assign rsp_if.found_position = rsp_pos_ff;
   assign rsp_if.bit_read       = rsp_bit_ff;
   assign rsp_if.error          = rsp_err_ff;

endmodule

// ===== hdl/bit_vector_rank_select.sv =====
// ----------------------------------------------------------------------------
// Bit vector rank/select
// Succinct bit vector with append, table build, rank, select and bit read.
//
//   Channel  Direction  Word
//   req_if   in         operation, bit_value, position, occurrence
//   rsp_if   out        count, found_position, bit_read, error
//
// After reset the bit memory is cleared one word per cycle with ready low.
// Rank makes three table/word reads in parallel. Build walks every word up
// to and including the word at the length. Select makes at most 9 search
// steps, scans at most 7 blocks and then narrows down to the bit. A stalled
// response holds the sequencer in its output state; one finished word may
// wait in the register.
// ----------------------------------------------------------------------------
module bit_vector_rank_select import bvrs_pkg::*; (
   input logic        clock,
   input logic        reset,
   bvrs_req_if.sink   req_if,
   bvrs_rsp_if.source rsp_if
);

   word_mem_req_type  word_req;
   super_mem_req_type super_req;
   block_mem_req_type block_req;
   logic [31:0]       word_rdata;
   logic [16:0]       super_rdata;
   logic [7:0]        block_rdata;

   // Sequencer.
   bvrs_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_if),
      .rsp_if      (rsp_if),
      .word_req    (word_req),
      .word_rdata  (word_rdata),
      .super_req   (super_req),
      .super_rdata (super_rdata),
      .block_req   (block_req),
      .block_rdata (block_rdata)
   );

   // Stored bits.
   bvrs_ram #(.WIDTH(32), .DEPTH(NWORDS)) u_word_mem (
      .clock (clock),
      .we    (word_req.we),
      .waddr (word_req.waddr),
      .wdata (word_req.wdata),
      .raddr (word_req.raddr),
      .rdata (word_rdata)
   );

   // Ones before each superblock.
   bvrs_ram #(.WIDTH(17), .DEPTH(NSUPERS)) u_super_mem (
      .clock (clock),
      .we    (super_req.we),
      .waddr (super_req.waddr),
      .wdata (super_req.wdata),
      .raddr (super_req.raddr),
      .rdata (super_rdata)
   );

   // Ones before each word within its superblock.
   bvrs_ram #(.WIDTH(8), .DEPTH(NBLOCKS)) u_block_mem (
      .clock (clock),
      .we    (block_req.we),
      .waddr (block_req.waddr),
      .wdata (block_req.wdata),
      .raddr (block_req.raddr),
      .rdata (block_rdata)
   );

endmodule

// ===== hdl/bvrs_checker.sv =====
// ----------------------------------------------------------------------------
// Bit vector rank/select checker
// Port-level checks on the handshakes and the response words.
// ----------------------------------------------------------------------------
module bvrs_props import bvrs_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic [2:0]  req_operation,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [16:0] rsp_count,
   input logic [15:0] rsp_found_position,
   input logic        rsp_bit_read,
   input logic        rsp_error
);

   // The clearing pass keeps requests out right after reset.
   a_clear_after_reset: assert property (@(posedge clock)
      reset |=> !req_ready)
      else $error("request accepted during clearing pass");

   // A read keeps the sequencer busy after it is taken, so ready drops.
   a_read_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_operation == OP_READ |=> !req_ready)
      else $error("ready right after a read request");

   // An error word carries no other result.
   a_error_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_error |->
         rsp_count == 17'd0 && rsp_found_position == 16'd0 && !rsp_bit_read)
      else $error("error word with result fields set");

   // A rank count excludes other results.
   a_rank_alone: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_count != 17'd0 |-> rsp_found_position == 16'd0 && !rsp_bit_read)
      else $error("rank count mixed with other results");

   // A stalled response word holds.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count) &&
         $stable(rsp_found_position) && $stable(rsp_bit_read) && $stable(rsp_error))
      else $error("stalled response word changed");

endmodule

bind bit_vector_rank_select bvrs_props u_bvrs_props (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_if.valid),
   .req_ready          (req_if.ready),
   .req_operation      (req_if.operation),
   .rsp_valid          (rsp_if.valid),
   .rsp_ready          (rsp_if.ready),
   .rsp_count          (rsp_if.count),
   .rsp_found_position (rsp_if.found_position),
   .rsp_bit_read       (rsp_if.bit_read),
   .rsp_error          (rsp_if.error)
);
